// ----- rtl/cau_pkg.sv -----
// shared types, constants and saturation helper for the complex arithmetic unit
`default_nettype none

package cau_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * WORD_BITS;
    localparam int SUM_W      = PROD_W + 2;
    localparam int NUM_W      = PROD_W + FRAC_BITS;
    localparam int REM_W      = PROD_W + WORD_BITS;
    localparam int ROOT_W     = WORD_BITS;
    localparam int SQR_W      = PROD_W + 2;
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int RES_LATENCY = WORD_BITS + 6;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_CONJ  = 3'd4;
    localparam logic [2:0] OP_MOD   = 3'd5;
    localparam logic [2:0] OP_EQ    = 3'd6;
    localparam logic [2:0] OP_MODEQ = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [PROD_W-1:0]    t_prod;
    typedef logic signed [SUM_W-1:0]     t_sum;

    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic [2:0] func;
        t_word      a_re;
        t_word      a_im;
        t_word      b_re;
        t_word      b_im;
        t_prod      prod_rr;
        t_prod      prod_ii;
        t_prod      prod_ri;
        t_prod      prod_ir;
        t_prod      prod_bbr;
        t_prod      prod_bbi;
    } t_item;

    typedef struct packed {
        t_word      re;
        t_word      im;
        logic       eq;
        logic [1:0] st;
    } t_res;

    typedef struct packed {
        logic  sat;
        t_word val;
    } t_sat;

    function automatic t_sat sat_word(input t_sum v);
        t_sat                     s;
        logic [SUM_W-WORD_BITS:0] top;
        top = v[SUM_W-1:WORD_BITS-1];
        if (top == '0 || top == '1) begin
            s.sat = 1'b0;
            s.val = v[WORD_BITS-1:0];
        end else begin
            s.sat = 1'b1;
            s.val = v[SUM_W-1] ? WORD_MIN : WORD_MAX;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cau_front.sv -----
// front end: takes a command and forms the operand products
`default_nettype none

module cau_front import cau_pkg::*; (
    input  wire logic       i_start,
    input  wire logic       i_full,
    input  wire logic [2:0] i_func,
    input  wire t_word      i_a_re,
    input  wire t_word      i_a_im,
    input  wire t_word      i_b_re,
    input  wire t_word      i_b_im,
    output logic            o_push,
    output t_item           o_item
);

    logic  w_sq;
    t_word w_mr;
    t_word w_mi;

    // modulus operations square a instead of multiplying by b
    assign w_sq = i_func inside {OP_MOD, OP_MODEQ};
    assign w_mr = w_sq ? i_a_re : i_b_re;
    assign w_mi = w_sq ? i_a_im : i_b_im;

    assign o_push = i_start && !i_full;

    always_comb begin
        o_item.func     = i_func;
        o_item.a_re     = i_a_re;
        o_item.a_im     = i_a_im;
        o_item.b_re     = i_b_re;
        o_item.b_im     = i_b_im;
        o_item.prod_rr  = t_prod'(i_a_re) * t_prod'(w_mr);
        o_item.prod_ii  = t_prod'(i_a_im) * t_prod'(w_mi);
        o_item.prod_ri  = t_prod'(i_a_re) * t_prod'(i_b_im);
        o_item.prod_ir  = t_prod'(i_a_im) * t_prod'(i_b_re);
        o_item.prod_bbr = t_prod'(i_b_re) * t_prod'(i_b_re);
        o_item.prod_bbi = t_prod'(i_b_im) * t_prod'(i_b_im);
    end

endmodule

`default_nettype wire

// ----- rtl/cau_fifo.sv -----
// short queue between the front end and the execution pipeline
`default_nettype none

module cau_fifo import cau_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_data,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_item      o_data
);

    t_item            r_mem [0:FIFO_DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == (PTR_W+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// ----- rtl/cau_back.sv -----
// execution pipeline: sums, saturation, bit-per-stage divider and square root
`default_nettype none

module cau_back import cau_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_strobe,
    output t_res       o_res
);

    typedef struct packed {
        logic [2:0] func;
        t_sum       r0;
        t_sum       r1;
        t_sum       den;
        logic       eq;
        logic       dz;
    } t_e1;

    typedef struct packed {
        logic [2:0]       func;
        t_res             res;
        logic             dz;
        logic             neg_re;
        logic             neg_im;
        logic [NUM_W-1:0] n_re;
        logic [NUM_W-1:0] n_im;
        logic [PROD_W-1:0] den;
        logic [PROD_W-1:0] x;
    } t_e2;

    typedef struct packed {
        logic [2:0]           func;
        t_res                 res;
        logic                 dz;
        logic                 neg_re;
        logic                 neg_im;
        logic                 ovf_re;
        logic                 ovf_im;
        logic [PROD_W-1:0]    den;
        logic [REM_W-1:0]     rem_re;
        logic [REM_W-1:0]     rem_im;
        logic [WORD_BITS-1:0] q_re;
        logic [WORD_BITS-1:0] q_im;
        logic [PROD_W-1:0]    sq_rem;
        logic [ROOT_W-1:0]    root;
    } t_dv;

    logic  r_e0_v, r_e1_v, r_e2_v, r_out_v;
    t_item r_e0;
    t_e1   r_e1, n_e1;
    t_e2   r_e2, n_e2;
    t_res  r_out, n_out;
    logic  r_dv_v [0:WORD_BITS];
    t_dv   r_dv   [0:WORD_BITS];
    t_dv   n_dv   [0:WORD_BITS];

    function automatic t_sat div_part(input logic neg, input logic ovf,
                                      input logic [WORD_BITS-1:0] q);
        t_sat s;
        t_sum m;
        m = '0;
        m[WORD_BITS-1:0] = q;
        if (ovf) begin
            s.sat = 1'b1;
            s.val = neg ? WORD_MIN : WORD_MAX;
        end else begin
            s = sat_word(neg ? -m : m);
        end
        return s;
    endfunction

    // stage 1: sums of operands or of products, and compare and zero flags
    always_comb begin
        n_e1.func = r_e0.func;
        n_e1.r0   = '0;
        n_e1.r1   = '0;
        n_e1.den  = t_sum'(r_e0.prod_bbr) + t_sum'(r_e0.prod_bbi);
        n_e1.eq   = (r_e0.a_re == r_e0.b_re) && (r_e0.a_im == r_e0.b_im);
        n_e1.dz   = (r_e0.b_re == '0) && (r_e0.b_im == '0);
        case (r_e0.func)
            OP_ADD: begin
                n_e1.r0 = t_sum'(r_e0.a_re) + t_sum'(r_e0.b_re);
                n_e1.r1 = t_sum'(r_e0.a_im) + t_sum'(r_e0.b_im);
            end
            OP_SUB: begin
                n_e1.r0 = t_sum'(r_e0.a_re) - t_sum'(r_e0.b_re);
                n_e1.r1 = t_sum'(r_e0.a_im) - t_sum'(r_e0.b_im);
            end
            OP_MUL: begin
                n_e1.r0 = t_sum'(r_e0.prod_rr) - t_sum'(r_e0.prod_ii);
                n_e1.r1 = t_sum'(r_e0.prod_ri) + t_sum'(r_e0.prod_ir);
            end
            OP_DIV: begin
                n_e1.r0 = t_sum'(r_e0.prod_rr) + t_sum'(r_e0.prod_ii);
                n_e1.r1 = t_sum'(r_e0.prod_ir) - t_sum'(r_e0.prod_ri);
            end
            OP_CONJ: begin
                n_e1.r0 = t_sum'(r_e0.a_re);
                n_e1.r1 = -t_sum'(r_e0.a_im);
            end
            OP_MOD, OP_MODEQ: begin
                n_e1.r0 = t_sum'(r_e0.prod_rr) + t_sum'(r_e0.prod_ii);
            end
            default: begin
                n_e1.r0 = '0;
            end
        endcase
    end

    // stage 2: saturation of direct results, compare flags, numerator magnitudes for the divider
    t_sum w_r0, w_r1, w_r0_sh, w_r1_sh, w_ng0, w_ng1, w_mag0, w_mag1;
    t_sat w_s0, w_s1;

    assign w_r0    = r_e1.r0;
    assign w_r1    = r_e1.r1;
    assign w_r0_sh = w_r0 >>> FRAC_BITS;
    assign w_r1_sh = w_r1 >>> FRAC_BITS;
    assign w_s0    = sat_word((r_e1.func == OP_MUL) ? w_r0_sh : w_r0);
    assign w_s1    = sat_word((r_e1.func == OP_MUL) ? w_r1_sh : w_r1);
    assign w_ng0   = -w_r0;
    assign w_ng1   = -w_r1;
    assign w_mag0  = w_r0[SUM_W-1] ? w_ng0 : w_r0;
    assign w_mag1  = w_r1[SUM_W-1] ? w_ng1 : w_r1;

    always_comb begin
        n_e2.func   = r_e1.func;
        n_e2.res    = '0;
        n_e2.dz     = r_e1.dz;
        n_e2.neg_re = w_r0[SUM_W-1];
        n_e2.neg_im = w_r1[SUM_W-1];
        n_e2.n_re   = NUM_W'(w_mag0[PROD_W-1:0]) << FRAC_BITS;
        n_e2.n_im   = NUM_W'(w_mag1[PROD_W-1:0]) << FRAC_BITS;
        n_e2.den    = r_e1.den[PROD_W-1:0];
        n_e2.x      = w_r0[PROD_W-1:0];
        case (r_e1.func)
            OP_ADD, OP_SUB, OP_MUL, OP_CONJ: begin
                n_e2.res.re = w_s0.val;
                n_e2.res.im = w_s1.val;
                n_e2.res.st = (w_s0.sat || w_s1.sat) ? ST_SAT : ST_OK;
            end
            OP_EQ: begin
                n_e2.res.eq = r_e1.eq;
            end
            OP_MODEQ: begin
                n_e2.res.eq = (r_e1.r0 == r_e1.den);
            end
            default: begin
                n_e2.res = '0;
            end
        endcase
    end

    // stage 3: quotient range check and divider and square root setup
    always_comb begin
        n_dv[0].func   = r_e2.func;
        n_dv[0].res    = r_e2.res;
        n_dv[0].dz     = r_e2.dz;
        n_dv[0].neg_re = r_e2.neg_re;
        n_dv[0].neg_im = r_e2.neg_im;
        n_dv[0].ovf_re = REM_W'(r_e2.n_re) >= (REM_W'(r_e2.den) << WORD_BITS);
        n_dv[0].ovf_im = REM_W'(r_e2.n_im) >= (REM_W'(r_e2.den) << WORD_BITS);
        n_dv[0].den    = r_e2.den;
        n_dv[0].rem_re = REM_W'(r_e2.n_re);
        n_dv[0].rem_im = REM_W'(r_e2.n_im);
        n_dv[0].q_re   = '0;
        n_dv[0].q_im   = '0;
        n_dv[0].sq_rem = r_e2.x;
        n_dv[0].root   = '0;
    end

    // one quotient bit and one root bit per stage
    for (genvar j = 0; j < WORD_BITS; j++) begin : g_bit
        localparam int K = WORD_BITS - 1 - j;
        logic [REM_W-1:0] w_dsh;
        logic [SQR_W-1:0] w_trial;

        assign w_dsh   = REM_W'(r_dv[j].den) << K;
        assign w_trial = (SQR_W'(r_dv[j].root) << (K + 1)) + (SQR_W'(1) << (2 * K));

        always_comb begin
            n_dv[j+1] = r_dv[j];
            if (r_dv[j].rem_re >= w_dsh) begin
                n_dv[j+1].rem_re = r_dv[j].rem_re - w_dsh;
                n_dv[j+1].q_re[K] = 1'b1;
            end
            if (r_dv[j].rem_im >= w_dsh) begin
                n_dv[j+1].rem_im = r_dv[j].rem_im - w_dsh;
                n_dv[j+1].q_im[K] = 1'b1;
            end
            if (SQR_W'(r_dv[j].sq_rem) >= w_trial) begin
                n_dv[j+1].sq_rem = r_dv[j].sq_rem - w_trial[PROD_W-1:0];
                n_dv[j+1].root[K] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j+1] <= 1'b0;
            end else begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv[j+1] <= n_dv[j+1];
        end
    end

    // final selection
    t_sat w_dq_re, w_dq_im, w_sr;
    t_sum w_root;

    always_comb begin
        w_root = '0;
        w_root[ROOT_W-1:0] = r_dv[WORD_BITS].root;
    end

    assign w_dq_re = div_part(r_dv[WORD_BITS].neg_re, r_dv[WORD_BITS].ovf_re,
                              r_dv[WORD_BITS].q_re);
    assign w_dq_im = div_part(r_dv[WORD_BITS].neg_im, r_dv[WORD_BITS].ovf_im,
                              r_dv[WORD_BITS].q_im);
    assign w_sr    = sat_word(w_root);

    always_comb begin
        n_out = r_dv[WORD_BITS].res;
        case (r_dv[WORD_BITS].func)
            OP_DIV: begin
                if (r_dv[WORD_BITS].dz) begin
                    n_out    = '0;
                    n_out.st = ST_DIV0;
                end else begin
                    n_out.re = w_dq_re.val;
                    n_out.im = w_dq_im.val;
                    n_out.eq = 1'b0;
                    n_out.st = (w_dq_re.sat || w_dq_im.sat) ? ST_SAT : ST_OK;
                end
            end
            OP_MOD: begin
                n_out    = '0;
                n_out.re = w_sr.val;
                n_out.st = w_sr.sat ? ST_SAT : ST_OK;
            end
            default: begin
                n_out = r_dv[WORD_BITS].res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_v    <= 1'b0;
            r_e1_v    <= 1'b0;
            r_e2_v    <= 1'b0;
            r_dv_v[0] <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_e0_v    <= i_valid;
            r_e1_v    <= r_e0_v;
            r_e2_v    <= r_e1_v;
            r_dv_v[0] <= r_e2_v;
            r_out_v   <= r_dv_v[WORD_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_e0 <= i_item;
        end
        r_e1    <= n_e1;
        r_e2    <= n_e2;
        r_dv[0] <= n_dv[0];
        r_out   <= n_out;
    end

    assign o_strobe = r_out_v;
    assign o_res    = r_out;

endmodule

`default_nettype wire

// ----- rtl/complex_arithmetic_unit.sv -----
// top level of the complex arithmetic unit
`default_nettype none

// Complex arithmetic on signed Q16.16 operands a and b.
// Command channel: i_func and the four operand parts are taken at a rising
// edge where start is high and busy is low. One command can be taken on
// every clock edge.
// Result channel: o_strobe marks a single cycle in which o_res_re, o_res_im,
// o_is_equal and o_status hold one result. The receiver cannot hold results
// off; each result must be captured in its strobe cycle.
// Path: each command passes the queue and then the registers r_e0, r_e1,
// r_e2, r_dv and r_out, the same path for every operation. Results leave in
// command order. The length is set by the division and square root, which
// resolve one quotient bit and one root bit per pipeline stage over 32 stages.
// Throughput: one command per cycle; the execution pipeline never stalls, so
// the two-entry queue behind the front end never fills and busy stays low
// in normal use.
// Reset (synchronous, active low) empties the queue and drops every command
// in flight; no strobe follows a reset cycle.

module complex_arithmetic_unit import cau_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] i_func,
    input  wire t_word      i_a_re,
    input  wire t_word      i_a_im,
    input  wire t_word      i_b_re,
    input  wire t_word      i_b_im,
    output logic            o_strobe,
    output t_word           o_res_re,
    output t_word           o_res_im,
    output logic            o_is_equal,
    output logic [1:0]      o_status
);

    logic  w_push, w_full, w_empty;
    t_item w_item, w_head;
    t_res  w_res;

    cau_front u_front (
        .i_start (start),
        .i_full  (w_full),
        .i_func  (i_func),
        .i_a_re  (i_a_re),
        .i_a_im  (i_a_im),
        .i_b_re  (i_b_re),
        .i_b_im  (i_b_im),
        .o_push  (w_push),
        .o_item  (w_item)
    );

    cau_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_item),
        .i_pop   (!w_empty),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_head)
    );

    cau_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!w_empty),
        .i_item   (w_head),
        .o_strobe (o_strobe),
        .o_res    (w_res)
    );

    assign busy       = w_full;
    assign o_res_re   = w_res.re;
    assign o_res_im   = w_res.im;
    assign o_is_equal = w_res.eq;
    assign o_status   = w_res.st;

endmodule

`default_nettype wire

// ----- rtl/cau_checker.sv -----
// port-level checks for the complex arithmetic unit and their binding
`default_nettype none

module cau_checker import cau_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_strobe,
    input wire t_word      o_res_re,
    input wire t_word      o_res_im,
    input wire logic       o_is_equal,
    input wire logic [1:0] o_status
);

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("result transfer right after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, RES_LATENCY))
        else $error("result transfer without a command at the expected latency");

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_DIV0) |->
            (o_res_re == '0 && o_res_im == '0 && !o_is_equal))
        else $error("division by zero with nonzero result");

    a_equal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_equal) |->
            (o_status == ST_OK && o_res_re == '0 && o_res_im == '0))
        else $error("compare result with numeric fields or status set");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_strobe   (o_strobe),
    .o_res_re   (o_res_re),
    .o_res_im   (o_res_im),
    .o_is_equal (o_is_equal),
    .o_status   (o_status)
);

`default_nettype wire

// ----- sim/complex_arithmetic_unit_tb.sv -----
// testbench for the complex arithmetic unit: directed and random commands checked against a predictor
`default_nettype none

module complex_arithmetic_unit_tb;
    import cau_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [2:0] i_func;
    t_word      i_a_re, i_a_im, i_b_re, i_b_im;
    logic       o_strobe;
    t_word      o_res_re, o_res_im;
    logic       o_is_equal;
    logic [1:0] o_status;

    typedef struct {
        t_word      re;
        t_word      im;
        logic       eq;
        logic [1:0] st;
    } t_answer;

    t_answer answers_due[$];
    int      errors;
    int      cycles;

    complex_arithmetic_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_a_re(i_a_re), .i_a_im(i_a_im),
        .i_b_re(i_b_re), .i_b_im(i_b_im), .o_strobe(o_strobe),
        .o_res_re(o_res_re), .o_res_im(o_res_im),
        .o_is_equal(o_is_equal), .o_status(o_status)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // clamp a wide value to the word range, flagging saturation
    function automatic t_word clamp_word(input logic signed [255:0] v, inout logic sat);
        if (v > 256'sh7fffffff) begin
            sat = 1'b1;
            return WORD_MAX;
        end else if (v < -256'sh80000000) begin
            sat = 1'b1;
            return WORD_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [255:0] floor_sqrt(input logic signed [255:0] x);
        logic signed [255:0] r, c;
        r = 0;
        for (int k = 40; k >= 0; k--) begin
            c = r | (256'sd1 <<< k);
            if (c * c <= x) r = c;
        end
        return r;
    endfunction

    function automatic t_answer complex_result(input logic [2:0] f, input t_word ar,
                                               input t_word ai, input t_word br,
                                               input t_word bi);
        logic signed [255:0] xr, xi, den, na, nb, wr, wi, vr, vi;
        logic    sat, numeric;
        t_answer a;
        xr = 0;
        xi = 0;
        sat = 1'b0;
        numeric = 1'b1;
        a.eq = 1'b0;
        a.st = ST_OK;
        wr = ar;
        wi = ai;
        vr = br;
        vi = bi;
        case (f)
            OP_ADD: begin
                xr = wr + vr;
                xi = wi + vi;
            end
            OP_SUB: begin
                xr = wr - vr;
                xi = wi - vi;
            end
            OP_MUL: begin
                xr = (wr * vr - wi * vi) >>> FRAC_BITS;
                xi = (wr * vi + wi * vr) >>> FRAC_BITS;
            end
            OP_DIV: begin
                if (br == 0 && bi == 0) begin
                    a.st = ST_DIV0;
                end else begin
                    den = vr * vr + vi * vi;
                    na = (wr * vr + wi * vi) <<< FRAC_BITS;
                    nb = (wi * vr - wr * vi) <<< FRAC_BITS;
                    // signed division in sv truncates toward zero
                    xr = na / den;
                    xi = nb / den;
                end
            end
            OP_CONJ: begin
                xr = wr;
                xi = -wi;
            end
            OP_MOD: xr = floor_sqrt(wr * wr + wi * wi);
            OP_EQ: begin
                numeric = 1'b0;
                a.eq = (ar == br) && (ai == bi);
            end
            default: begin
                numeric = 1'b0;
                a.eq = (wr * wr + wi * wi) == (vr * vr + vi * vi);
            end
        endcase
        a.re = clamp_word(xr, sat);
        a.im = clamp_word(xi, sat);
        if (numeric && a.st == ST_OK && sat) a.st = ST_SAT;
        return a;
    endfunction

    // check each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_strobe) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result re=%h im=%h", $time, o_res_re, o_res_im);
                errors++;
            end else begin
                e = answers_due.pop_front();
                if (o_res_re !== e.re) begin
                    $display("%0t: res_re expected %h actual %h", $time, e.re, o_res_re);
                    errors++;
                end
                if (o_res_im !== e.im) begin
                    $display("%0t: res_im expected %h actual %h", $time, e.im, o_res_im);
                    errors++;
                end
                if (o_is_equal !== e.eq) begin
                    $display("%0t: is_equal expected %b actual %b", $time, e.eq, o_is_equal);
                    errors++;
                end
                if (o_status !== e.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, o_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    int burst_left;

    // one command transfer, with random gaps between bursts
    task automatic send_command(input logic [2:0] f, input t_word ar, input t_word ai,
                                input t_word br, input t_word bi);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start  <= 1'b1;
        i_func <= f;
        i_a_re <= ar;
        i_a_im <= ai;
        i_b_re <= br;
        i_b_im <= bi;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        answers_due.push_back(complex_result(f, ar, ai, br, bi));
    endtask

    function automatic t_word any_word();
        case ($urandom_range(0, 5))
            0: return WORD_MAX - $urandom_range(0, 2);
            1: return WORD_MIN + $urandom_range(0, 2);
            2: return $signed($urandom_range(0, 8)) - 4;
            3: return $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_extremes();
        t_word v[5];
        v = '{WORD_MAX, WORD_MIN, 32'sd0, -32'sd1, 32'sh00010000};
        for (int f = 0; f < 8; f++) begin
            send_command(f[2:0], v[f % 5], v[(f + 1) % 5], v[(f + 3) % 5], v[(f + 2) % 5]);
        end
    endtask

    task automatic test_special_cases();
        send_command(OP_DIV, 32'sh00030000, -32'sh00020000, 32'sd0, 32'sd0);
        send_command(OP_DIV, WORD_MAX, WORD_MAX, 32'sd1, 32'sd0);
        send_command(OP_DIV, -32'sh00050000, 32'sh00010000, 32'sh00020000, 32'sh00010000);
        send_command(OP_CONJ, 32'sd5, WORD_MIN, 32'sd0, 32'sd0);
        send_command(OP_MOD, WORD_MAX, WORD_MAX, 32'sd0, 32'sd0);
        send_command(OP_MOD, 32'sh00030000, 32'sh00040000, 32'sd0, 32'sd0);
        send_command(OP_MUL, -32'sd1, 32'sd0, 32'sd1, 32'sd0);
        send_command(OP_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX);
        send_command(OP_ADD, WORD_MAX, WORD_MIN, 32'sd1, -32'sd1);
        send_command(OP_SUB, WORD_MIN, WORD_MAX, 32'sd1, -32'sd1);
        send_command(OP_EQ, 32'sd7, -32'sd9, 32'sd7, -32'sd9);
        send_command(OP_EQ, 32'sd7, -32'sd9, 32'sd7, 32'sd9);
        send_command(OP_MODEQ, 32'sd3, 32'sd4, -32'sd4, 32'sd3);
        send_command(OP_MODEQ, 32'sd3, 32'sd4, 32'sd5, 32'sd1);
        send_command(OP_MODEQ, 32'sd3, 32'sd4, 32'sd5, 32'sd0);
    endtask

    task automatic test_random_commands(input int count);
        t_word ar, ai, br, bi;
        logic [2:0] f;
        for (int n = 0; n < count; n++) begin
            f = 3'($urandom_range(0, 7));
            ar = any_word();
            ai = any_word();
            br = any_word();
            bi = any_word();
            case ($urandom_range(0, 9))
                0: begin
                    br = ar;
                    bi = ai;
                end
                1: begin
                    br = -ai;
                    bi = ar;
                end
                2: if (f == OP_DIV) begin
                    br = 0;
                    bi = 0;
                end
                default: ;
            endcase
            send_command(f, ar, ai, br, bi);
        end
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        burst_left = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_func  <= OP_ADD;
        i_a_re  <= '0;
        i_a_im  <= '0;
        i_b_re  <= '0;
        i_b_im  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_special_cases();
        test_random_commands(1750);
        start <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (RES_LATENCY + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_fifo.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
rtl/cau_checker.sv
sim/complex_arithmetic_unit_tb.sv
